FILE: design/vlfd_pkg.sv
// Shared types and codes for the variable-length frame deframer.
package vlfd_pkg;

  localparam logic [2:0] ST_PROGRESS  = 3'd0;
  localparam logic [2:0] ST_READY     = 3'd1;
  localparam logic [2:0] ST_BAD_START = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_IGNORED   = 3'd4;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_BAD_START = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

  localparam logic [7:0] START_BYTE_RESET = 8'hAA;

  localparam logic [7:0] LEN_ONE_MASK  = 8'h80;
  localparam logic [7:0] LEN_TWO_MASK  = 8'hC0;
  localparam logic [7:0] LEN_TWO_CODE  = 8'h80;
  localparam logic [7:0] LEN_HIGH_MASK = 8'h3F;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  byte_out;
    logic [9:0]  byte_index;
    logic        byte_valid;
    logic [10:0] frame_length;
    logic [1:0]  last_error;
  } result_t;

endpackage

FILE: design/varlen_frame_deframer.sv
// Variable-length frame deframer: start byte check, length decode and byte indexing.
//
//   Channel   Signals                                   Direction
//   request   in_valid_i / in_ready_o, command, byte    in
//   result    out_valid_o / out_ready_i, six fields     out
//   config    cfg_we_i / cfg_wdata_i (start byte)       in
//
// One request is accepted per cycle while the skid register is empty.
// The result register plus a one-entry skid register keep the request side
// open while a result waits, so ready depends only on the skid register.
// Reset leaves the block idle: data bytes are ignored until a start command.
module varlen_frame_deframer
  import vlfd_pkg::*;
#(
  parameter int BUFFER_BYTES     = 1024,
  parameter int LENGTH_OFFSET    = 1,
  parameter int MIN_DECODE_BYTES = 2,
  parameter int HEADER_BYTES     = 2,
  parameter int TRAILER_BYTES    = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  byte_out_o,
  output logic [9:0]  byte_index_o,
  output logic        byte_valid_o,
  output logic [10:0] frame_length_o,
  output logic [1:0]  last_error_o
);

  localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_RECV  = 2'd1;
  localparam logic [1:0] MODE_READY = 2'd2;

  logic [7:0]       start_byte_q;
  logic [1:0]       mode_q, mode_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       len0_q, len0_d, len1_q, len1_d, len2_q, len2_d;
  logic             known_q, known_d;
  logic [CNT_W-1:0] exp_q, exp_d;
  logic [1:0]       err_q, err_d;

  logic [CNT_W-1:0] idx, cnt;
  logic [1:0]       need;
  logic [21:0]      payload;
  logic [23:0]      total;
  logic             accept, out_take;
  result_t          res;
  result_t          out_q, skid_q;
  logic             out_valid_q, skid_valid_q;

  assign accept   = in_valid_i & in_ready_o;
  assign out_take = out_valid_q & out_ready_i;
  assign in_ready_o = ~skid_valid_q;

  always_comb begin
    mode_d  = mode_q;
    count_d = count_q;
    len0_d  = len0_q;
    len1_d  = len1_q;
    len2_d  = len2_q;
    known_d = known_q;
    exp_d   = exp_q;
    err_d   = err_q;
    idx     = count_q;
    cnt     = count_q + CNT_W'(1);
    need    = 2'd1;
    payload = '0;
    total   = '0;
    res     = '0;

    if (command_i) begin
      mode_d  = MODE_RECV;
      count_d = '0;
      known_d = 1'b0;
      exp_d   = '0;
      res.status = ST_PROGRESS;
    end else if (mode_q != MODE_RECV) begin
      res.status   = ST_IGNORED;
      res.byte_out = rx_byte_i;
      res.frame_length = known_q ? 11'(exp_q) : 11'd0;
    end else begin
      count_d      = cnt;
      res.byte_out = rx_byte_i;
      res.byte_index = 10'(idx);
      if (idx == '0 && rx_byte_i != start_byte_q) begin
        err_d   = ERR_BAD_START;
        mode_d  = MODE_RECV;
        count_d = '0;
        known_d = 1'b0;
        exp_d   = '0;
        res.status = ST_BAD_START;
      end else begin
        if (idx == CNT_W'(LENGTH_OFFSET)) begin
          len0_d = rx_byte_i;
        end else if (idx == CNT_W'(LENGTH_OFFSET + 1)) begin
          len1_d = rx_byte_i;
        end else if (idx == CNT_W'(LENGTH_OFFSET + 2)) begin
          len2_d = rx_byte_i;
        end
        if ((len0_d & LEN_ONE_MASK) == 8'h00) begin
          need    = 2'd1;
          payload = {14'd0, len0_d};
        end else if ((len0_d & LEN_TWO_MASK) == LEN_TWO_CODE) begin
          need    = 2'd2;
          payload = {8'd0, len0_d[5:0] & LEN_HIGH_MASK[5:0], len1_d};
        end else begin
          need    = 2'd3;
          payload = {len0_d[5:0] & LEN_HIGH_MASK[5:0], len1_d, len2_d};
        end
        total = 24'(HEADER_BYTES) + 24'(need) + 24'(payload) + 24'(TRAILER_BYTES);
        if (!known_q && cnt >= CNT_W'(MIN_DECODE_BYTES) && cnt > CNT_W'(LENGTH_OFFSET)
            && cnt >= CNT_W'(LENGTH_OFFSET) + CNT_W'(need)) begin
          if (total > 24'(BUFFER_BYTES)) begin
            err_d = ERR_OVERFLOW;
          end else begin
            known_d = 1'b1;
            exp_d   = total[CNT_W-1:0];
          end
        end
        priority if (err_d == ERR_OVERFLOW && err_q != ERR_OVERFLOW && !known_d
                     && !known_q && total > 24'(BUFFER_BYTES)
                     && cnt >= CNT_W'(MIN_DECODE_BYTES) && cnt > CNT_W'(LENGTH_OFFSET)
                     && cnt >= CNT_W'(LENGTH_OFFSET) + CNT_W'(need)) begin
          mode_d  = MODE_RECV;
          count_d = '0;
          exp_d   = '0;
          res.status = ST_OVERFLOW;
        end else if (!known_q && !known_d && total > 24'(BUFFER_BYTES)
                     && cnt >= CNT_W'(MIN_DECODE_BYTES) && cnt > CNT_W'(LENGTH_OFFSET)
                     && cnt >= CNT_W'(LENGTH_OFFSET) + CNT_W'(need)) begin
          err_d   = ERR_OVERFLOW;
          mode_d  = MODE_RECV;
          count_d = '0;
          exp_d   = '0;
          res.status = ST_OVERFLOW;
        end else if (known_d && cnt >= exp_d) begin
          mode_d = MODE_READY;
          res.status     = ST_READY;
          res.byte_valid = 1'b1;
          res.frame_length = 11'(exp_d);
        end else if (cnt < CNT_W'(BUFFER_BYTES)) begin
          res.status     = ST_PROGRESS;
          res.byte_valid = 1'b1;
          res.frame_length = known_d ? 11'(exp_d) : 11'd0;
        end else begin
          err_d   = ERR_OVERFLOW;
          mode_d  = MODE_RECV;
          count_d = '0;
          known_d = 1'b0;
          exp_d   = '0;
          res.status = ST_OVERFLOW;
        end
      end
    end
    res.last_error = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= START_BYTE_RESET;
      mode_q       <= MODE_IDLE;
      count_q      <= '0;
      len0_q       <= '0;
      len1_q       <= '0;
      len2_q       <= '0;
      known_q      <= 1'b0;
      exp_q        <= '0;
      err_q        <= ERR_NONE;
    end else begin
      if (cfg_we_i) begin
        start_byte_q <= cfg_wdata_i;
      end
      if (accept) begin
        mode_q  <= mode_d;
        count_q <= count_d;
        len0_q  <= len0_d;
        len1_q  <= len1_d;
        len2_q  <= len2_d;
        known_q <= known_d;
        exp_q   <= exp_d;
        err_q   <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (!out_valid_q || out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign byte_out_o     = out_q.byte_out;
  assign byte_index_o   = out_q.byte_index;
  assign byte_valid_o   = out_q.byte_valid;
  assign frame_length_o = out_q.frame_length;
  assign last_error_o   = out_q.last_error;

endmodule

FILE: design/vlfd_checker.sv
// Port-level checker for the variable-length frame deframer, with its bind.
module vlfd_checker
  import vlfd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [9:0]  byte_index_o,
  input logic        byte_valid_o,
  input logic [10:0] frame_length_o,
  input logic [1:0]  last_error_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_valid_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |-> status_o == ST_PROGRESS || status_o == ST_READY)
    else $error("byte marked valid on a failed or ignored request");

  a_bad_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_BAD_START |->
      last_error_o == ERR_BAD_START && frame_length_o == 11'd0 && byte_index_o == 10'd0)
    else $error("bad start result inconsistent");

  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OVERFLOW |->
      last_error_o == ERR_OVERFLOW && frame_length_o == 11'd0)
    else $error("overflow result inconsistent");

  a_ready_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_READY |-> frame_length_o != 11'd0)
    else $error("frame ready without a decoded length");

endmodule

bind varlen_frame_deframer vlfd_checker u_vlfd_checker (.*);

FILE: tb/tb_varlen_frame_deframer.sv
// Self-checking testbench for the variable-length frame deframer with a built-in predictor.
module tb_varlen_frame_deframer
  import vlfd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD       = 10;
  localparam int BUFFER_BYTES     = 1024;
  localparam int LENGTH_OFFSET    = 1;
  localparam int MIN_DECODE_BYTES = 2;
  localparam int HEADER_BYTES     = 2;
  localparam int TRAILER_BYTES    = 2;
  localparam int ITEMS_PER_PHASE  = 20;
  localparam int NUM_PHASES       = 4;
  localparam int SETTLE_CYCLES    = 4;
  localparam int WATCHDOG_LIMIT   = 2000;

  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_START = 1'b1;

  localparam result_t PREDICTED = '0;

  typedef enum logic [1:0] {RX_IDLE, RX_RECV, RX_READY} rx_state_e;

  typedef struct {
    logic       cmd;
    logic [7:0] data;
    logic       typed;
    result_t    want;
  } request_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = 8'h00;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        command_i = CMD_DATA;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [7:0]  byte_out_o;
  logic [9:0]  byte_index_o;
  logic        byte_valid_o;
  logic [10:0] frame_length_o;
  logic [1:0]  last_error_o;

  rx_state_e   rx_state = RX_IDLE;
  int          rx_count = 0;
  logic [7:0]  len_byte [3] = '{8'h00, 8'h00, 8'h00};
  logic        length_known = 1'b0;
  int          expected_total = 0;
  logic [1:0]  sticky_error = ERR_NONE;
  logic [7:0]  start_value = START_BYTE_RESET;

  result_t     expected_q [$];
  request_t    directed_rows [$];
  request_t    frame_plan [$];
  int          mismatches = 0;
  int          total_requests = 0;
  int          status_seen [5] = '{0, 0, 0, 0, 0};
  int          quiet_cycles = 0;
  logic        calm = 1'b0;

  varlen_frame_deframer #(
    .BUFFER_BYTES    (BUFFER_BYTES),
    .LENGTH_OFFSET   (LENGTH_OFFSET),
    .MIN_DECODE_BYTES(MIN_DECODE_BYTES),
    .HEADER_BYTES    (HEADER_BYTES),
    .TRAILER_BYTES   (TRAILER_BYTES)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .byte_out_o    (byte_out_o),
    .byte_index_o  (byte_index_o),
    .byte_valid_o  (byte_valid_o),
    .frame_length_o(frame_length_o),
    .last_error_o  (last_error_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic void begin_reception();
    rx_state = RX_RECV;
    rx_count = 0;
    length_known = 1'b0;
    expected_total = 0;
  endfunction

  function automatic result_t deframe_byte(input logic cmd, input logic [7:0] data);
    result_t r;
    int      idx;
    int      need;
    int      payload;
    logic    overflowed;
    r = '0;
    overflowed = 1'b0;
    if (cmd == CMD_START) begin
      begin_reception();
      r.status = ST_PROGRESS;
    end else if (rx_state != RX_RECV) begin
      r.status = ST_IGNORED;
      r.byte_out = data;
    end else begin
      idx = rx_count;
      rx_count = rx_count + 1;
      r.byte_out = data;
      r.byte_index = 10'(idx);
      if (idx == 0 && data != start_value) begin
        sticky_error = ERR_BAD_START;
        begin_reception();
        r.status = ST_BAD_START;
      end else begin
        if (idx == LENGTH_OFFSET) len_byte[0] = data;
        else if (idx == LENGTH_OFFSET + 1) len_byte[1] = data;
        else if (idx == LENGTH_OFFSET + 2) len_byte[2] = data;
        if (!length_known && rx_count >= MIN_DECODE_BYTES && rx_count > LENGTH_OFFSET) begin
          if ((len_byte[0] & LEN_ONE_MASK) == 8'h00) begin
            need = 1;
            payload = int'(len_byte[0]);
          end else if ((len_byte[0] & LEN_TWO_MASK) == LEN_TWO_CODE) begin
            need = 2;
            payload = (int'(len_byte[0] & LEN_HIGH_MASK) << 8) | int'(len_byte[1]);
          end else begin
            need = 3;
            payload = (int'(len_byte[0] & LEN_HIGH_MASK) << 16) |
                      (int'(len_byte[1]) << 8) | int'(len_byte[2]);
          end
          if (rx_count - LENGTH_OFFSET >= need) begin
            if (HEADER_BYTES + need + payload + TRAILER_BYTES > BUFFER_BYTES) begin
              sticky_error = ERR_OVERFLOW;
              begin_reception();
              r.status = ST_OVERFLOW;
              overflowed = 1'b1;
            end else begin
              expected_total = HEADER_BYTES + need + payload + TRAILER_BYTES;
              length_known = 1'b1;
            end
          end
        end
        if (!overflowed) begin
          if (length_known && rx_count >= expected_total) begin
            rx_state = RX_READY;
            r.status = ST_READY;
            r.byte_valid = 1'b1;
          end else if (rx_count < BUFFER_BYTES) begin
            r.status = ST_PROGRESS;
            r.byte_valid = 1'b1;
          end else begin
            sticky_error = ERR_OVERFLOW;
            begin_reception();
            r.status = ST_OVERFLOW;
          end
        end
      end
    end
    r.frame_length = length_known ? 11'(expected_total) : 11'd0;
    r.last_error = sticky_error;
    return r;
  endfunction

  function automatic void plan_request(input logic cmd, input logic [7:0] data);
    frame_plan.push_back('{cmd, data, 1'b0, PREDICTED});
  endfunction

  function automatic void report_mismatch(input string field, input int unsigned want,
                                          input int unsigned got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    mismatches++;
  endfunction

  task automatic send_request(input request_t req);
    result_t predicted;
    if (!calm) begin
      while ($urandom_range(99) < 33) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    command_i <= req.cmd;
    rx_byte_i <= req.data;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = deframe_byte(req.cmd, req.data);
    expected_q.push_back(req.typed ? req.want : predicted);
    total_requests++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 33);
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with no request pending, status %0d", $time, status_o);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (want.status != status_o) report_mismatch("status", want.status, status_o);
          if (want.byte_out != byte_out_o) report_mismatch("byte_out", want.byte_out, byte_out_o);
          if (want.byte_index != byte_index_o)
            report_mismatch("byte_index", want.byte_index, byte_index_o);
          if (want.byte_valid != byte_valid_o)
            report_mismatch("byte_valid", want.byte_valid, byte_valid_o);
          if (want.frame_length != frame_length_o)
            report_mismatch("frame_length", want.frame_length, frame_length_o);
          if (want.last_error != last_error_o)
            report_mismatch("last_error", want.last_error, last_error_o);
          if (status_o <= ST_IGNORED) status_seen[status_o]++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int         sel;
    int         need;
    int         payload;
    int         fill;
    logic [7:0] lb [3];
    logic [7:0] setting;

    directed_rows = '{
      '{CMD_DATA,  8'hFF, 1'b1, '{ST_IGNORED, 8'hFF, 10'd0, 1'b0, 11'd0, ERR_NONE}},
      '{CMD_DATA,  8'h00, 1'b1, '{ST_IGNORED, 8'h00, 10'd0, 1'b0, 11'd0, ERR_NONE}},
      '{CMD_START, 8'h00, 1'b1, '{ST_PROGRESS, 8'h00, 10'd0, 1'b0, 11'd0, ERR_NONE}},
      '{CMD_DATA,  8'h55, 1'b1, '{ST_BAD_START, 8'h55, 10'd0, 1'b0, 11'd0, ERR_BAD_START}},
      '{CMD_DATA,  8'hAA, 1'b0, PREDICTED},
      '{CMD_DATA,  8'h00, 1'b0, PREDICTED},
      '{CMD_DATA,  8'h12, 1'b0, PREDICTED},
      '{CMD_DATA,  8'h34, 1'b0, PREDICTED},
      '{CMD_DATA,  8'hFF, 1'b0, PREDICTED},
      '{CMD_DATA,  8'h77, 1'b0, PREDICTED},
      '{CMD_START, 8'h00, 1'b0, PREDICTED},
      '{CMD_DATA,  8'hAA, 1'b0, PREDICTED},
      '{CMD_DATA,  8'hBF, 1'b0, PREDICTED},
      '{CMD_DATA,  8'hFF, 1'b0, PREDICTED},
      '{CMD_DATA,  8'hAA, 1'b0, PREDICTED},
      '{CMD_DATA,  8'hFF, 1'b0, PREDICTED},
      '{CMD_DATA,  8'hFF, 1'b0, PREDICTED},
      '{CMD_DATA,  8'hFF, 1'b0, PREDICTED},
      '{CMD_DATA,  8'hAA, 1'b0, PREDICTED},
      '{CMD_DATA,  8'h7F, 1'b0, PREDICTED},
      '{CMD_START, 8'h00, 1'b1, '{ST_PROGRESS, 8'h00, 10'd0, 1'b0, 11'd0, ERR_OVERFLOW}},
      '{CMD_DATA,  8'hAA, 1'b0, PREDICTED},
      '{CMD_DATA,  8'hC0, 1'b0, PREDICTED},
      '{CMD_DATA,  8'h00, 1'b0, PREDICTED},
      '{CMD_DATA,  8'h00, 1'b0, PREDICTED}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_request(directed_rows[i]);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      in_valid_i <= 1'b0;
      while (expected_q.size() != 0) @(posedge clk_i);
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      case (ph)
        0: setting = 8'h00;
        1: setting = 8'hFF;
        2: setting = 8'($urandom);
        default: setting = START_BYTE_RESET;
      endcase
      cfg_we_i <= 1'b1;
      cfg_wdata_i <= setting;
      @(posedge clk_i);
      start_value = setting;
      cfg_we_i <= 1'b0;
      calm = (ph == 2);

      frame_plan.delete();
      if (ph == 2) begin
        // A frame that fills the buffer exactly, then one that is one byte too long.
        plan_request(CMD_START, 8'h00);
        plan_request(CMD_DATA, setting);
        plan_request(CMD_DATA, 8'h83);
        plan_request(CMD_DATA, 8'hFA);
        repeat (BUFFER_BYTES - 3) plan_request(CMD_DATA, 8'($urandom));
        plan_request(CMD_DATA, 8'($urandom));
        plan_request(CMD_START, 8'h00);
        plan_request(CMD_DATA, setting);
        plan_request(CMD_DATA, 8'h83);
        plan_request(CMD_DATA, 8'hFB);
      end
      while (frame_plan.size() < ITEMS_PER_PHASE) begin
        sel = $urandom_range(99);
        if (sel < 10) begin
          repeat ($urandom_range(1, 6))
            plan_request(($urandom_range(4) == 0) ? CMD_START : CMD_DATA, 8'($urandom));
        end else begin
          if ($urandom_range(9) != 0) plan_request(CMD_START, 8'h00);
          plan_request(CMD_DATA, ($urandom_range(9) == 0) ? 8'($urandom) : setting);
          payload = $urandom_range(0, 24);
          case ($urandom_range(2))
            0: begin
              need = 1;
              lb[0] = 8'(payload);
            end
            1: begin
              need = 2;
              if ($urandom_range(39) == 0) payload = $urandom_range(25, 300);
              lb[0] = LEN_TWO_CODE | 8'(payload >> 8);
              lb[1] = 8'(payload);
            end
            default: begin
              need = 3;
              lb[0] = LEN_TWO_MASK;
              lb[1] = 8'h00;
              lb[2] = 8'(payload);
            end
          endcase
          fill = HEADER_BYTES + need + payload + TRAILER_BYTES - 1 - need;
          if ($urandom_range(9) == 0) fill = $urandom_range(0, fill);
          if ($urandom_range(11) == 0) begin
            if ($urandom_range(1) == 0) begin
              need = 2;
              lb[0] = 8'($urandom_range(8'h84, 8'hBF));
            end else begin
              need = 3;
              lb[0] = 8'($urandom_range(8'hC1, 8'hFF));
            end
            lb[1] = 8'($urandom);
            lb[2] = 8'($urandom);
            fill = $urandom_range(0, 3);
          end
          for (int k = 0; k < need; k++) plan_request(CMD_DATA, lb[k]);
          repeat (fill) plan_request(CMD_DATA, 8'($urandom));
          repeat ($urandom_range(0, 2)) plan_request(CMD_DATA, 8'($urandom));
        end
      end
      foreach (frame_plan[i]) send_request(frame_plan[i]);
    end

    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests over five start-byte settings, idle and ready byte drops,",
             total_requests);
    $display("%0d frames completed, %0d bad start bytes, %0d length overflows, %0d ignored bytes.",
             status_seen[ST_READY], status_seen[ST_BAD_START], status_seen[ST_OVERFLOW],
             status_seen[ST_IGNORED]);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
